// ----- design/lbsv_pkg.sv -----
// Shared types and constants for the vertex skinning block.
// No dependencies.
package lbsv_pkg;
    localparam int NumBones   = 64;
    localparam int FracBits   = 16;
    localparam int TableWords = (NumBones + 1) * 16;
    localparam int AddrW      = $clog2(TableWords);
    localparam int BoneW      = $clog2(NumBones);

    typedef struct packed {
        logic               action;
        logic [10:0]        bone_a;
        logic [5:0]         bone_b;
        logic [5:0]         bone_c;
        logic [5:0]         bone_d;
        logic [15:0]        weight_a;
        logic [15:0]        weight_b;
        logic [15:0]        weight_c;
        logic [15:0]        weight_d;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE, S_BLEND, S_COMB, S_APPLY, S_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647) return 32'sh7fffffff;
        if (x < -68'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [67:0] rnd(input logic signed [67:0] x,
                                               input int s);
        logic signed [67:0] h;
        h = 68'sd1 <<< (s - 1);
        return (x + h) >>> s;
    endfunction
endpackage

// ----- design/linear_blend_skinning_vertex.sv -----
// Vertex skinning with four bones: a skin beat passes the front queue, then the blend,
// combine and apply steps in order, using the matrix table and one shared
// multiply-accumulate unit; the back part takes no new beat until the output is taken.
// Write beats stream at one per cycle, stored one cycle after accept. Beats wait in
// the queue while a skin beat is in progress. Reset (synchronous, active low) clears
// control only; the table is undefined until written.
module linear_blend_skinning_vertex (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_action,
    input  logic [10:0]        i_bone_a,
    input  logic [5:0]         i_bone_b,
    input  logic [5:0]         i_bone_c,
    input  logic [5:0]         i_bone_d,
    input  logic [15:0]        i_weight_a,
    input  logic [15:0]        i_weight_b,
    input  logic [15:0]        i_weight_c,
    input  logic [15:0]        i_weight_d,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z
);
    import lbsv_pkg::*;
    t_item it, q_it;
    logic  q_v, q_pop;

    assign it = '{i_action, i_bone_a, i_bone_b, i_bone_c, i_bone_d, i_weight_a,
                  i_weight_b, i_weight_c, i_weight_d, i_pos_x, i_pos_y, i_pos_z};

    lbsv_front u_front (.i_clk, .i_rst_n, .i_valid, .o_stall, .i_item(it),
        .o_q_valid(q_v), .o_q_item(q_it), .i_q_pop(q_pop));

    lbsv_back u_back (.i_clk, .i_rst_n, .i_q_valid(q_v), .i_q_item(q_it),
        .o_q_pop(q_pop), .o_valid, .i_stall, .o_x(o_out_x), .o_y(o_out_y),
        .o_z(o_out_z));

`ifndef SYNTH
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_x)) else $error("out");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !q_pop) else $error("pop");
`endif
endmodule

// ----- design/lbsv_front.sv -----
// Front part: accepts items and queues them for the back part.
// Depends on lbsv_pkg.
module lbsv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lbsv_pkg::t_item i_item,
    output logic           o_q_valid,
    output lbsv_pkg::t_item o_q_item,
    input  logic           i_q_pop
);
    import lbsv_pkg::*;
    t_item r_q [2];
    logic  r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_stall   = (r_cnt == 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    wire push = i_valid && !o_stall;
    wire pop  = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ----- design/lbsv_back.sv -----
// Back part: matrix table, blend, combine and apply sequencer with one MAC.
// Depends on lbsv_pkg.
module lbsv_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  lbsv_pkg::t_item    i_q_item,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic signed [31:0] o_z
);
    import lbsv_pkg::*;

    logic signed [31:0] mem [TableWords];
    logic signed [31:0] r_rd;
    logic [AddrW-1:0]   rd_addr;
    logic               r_rdv;
    logic [15:0]        r_wt;

    t_state r_st, n_st;
    t_item  r_it;
    logic [5:0] r_i;
    logic [2:0] r_k;
    logic signed [31:0] r_b [16];
    logic signed [31:0] r_c [16];
    logic signed [67:0] r_acc;
    logic signed [31:0] r_o [3];
    logic r_ov;

    logic [10:0] bone;
    logic [15:0] wt;
    logic [3:0]  ei;
    logic [1:0]  er, ec;
    logic signed [67:0] prod;
    logic signed [31:0] opa, opb;

    always_comb begin
        unique case (r_k[1:0])
            2'd0: begin bone = r_it.bone_a; wt = r_it.weight_a; end
            2'd1: begin bone = {5'd0, r_it.bone_b}; wt = r_it.weight_b; end
            2'd2: begin bone = {5'd0, r_it.bone_c}; wt = r_it.weight_c; end
            default: begin bone = {5'd0, r_it.bone_d}; wt = r_it.weight_d; end
        endcase
    end

    // i: element index, col*4+row in blend and row*4+col in combine
    always_comb begin
        ei = r_i[3:0];
        er = r_i[3:2];
        ec = r_i[1:0];
        rd_addr = '0;
        unique case (r_st)
            S_BLEND: rd_addr = AddrW'({bone[BoneW-1:0], ei});
            S_COMB:  rd_addr = AddrW'(NumBones * 16) + AddrW'({r_k[1:0], er});
            default: rd_addr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[rd_addr];
        if (o_q_pop && !i_q_item.action && i_q_item.bone_a < 11'(TableWords))
            mem[i_q_item.bone_a[AddrW-1:0]] <= i_q_item.pos_x;
    end

    // One MAC operand pair per cycle; blend and combine use registered read data
    always_comb begin
        opa = 32'sd0; opb = 32'sd0;
        unique case (r_st)
            S_BLEND: begin opa = $signed({16'd0, r_wt}); opb = r_rd; end
            S_COMB:  begin opa = r_rd; opb = r_b[{ec, r_k[1:0] - 2'd1}]; end
            default: begin
                opa = r_c[{r_i[1:0], r_k[1:0]}];
                unique case (r_k[1:0])
                    2'd0: opb = r_it.pos_x;
                    2'd1: opb = r_it.pos_y;
                    default: opb = r_it.pos_z;
                endcase
            end
        endcase
        prod = 68'(opa) * 68'(opb);
    end

    logic last_k;
    always_comb begin
        n_st = r_st;
        o_q_pop = 1'b0;
        last_k = (r_k == 3'd4);
        unique case (r_st)
            S_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid && i_q_item.action) n_st = S_BLEND;
            end
            S_BLEND: if (last_k && r_i == 6'd15) n_st = S_COMB;
            S_COMB:  if (last_k && r_i == 6'd15) n_st = S_APPLY;
            S_APPLY: if (r_k == 3'd3 && r_i == 6'd2) n_st = S_OUT;
            default: if (!r_ov) n_st = S_IDLE;
        endcase
    end

    // r_k counts 0..4: cycle k issues read k; MAC uses read k-1
    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_it <= i_q_item;
        unique case (r_st)
            S_IDLE: begin r_i <= '0; r_k <= '0; r_acc <= '0; end
            S_BLEND, S_COMB: begin
                if (r_k != 3'd0) begin
                    if (r_st == S_COMB)
                        r_acc <= r_acc + rnd(prod, FracBits);
                    else if (r_rdv)
                        r_acc <= r_acc + prod;
                end
                if (last_k) begin
                    r_k <= '0;
                    r_i <= (r_i == 6'd15) ? 6'd0 : r_i + 6'd1;
                    r_acc <= '0;
                    if (r_st == S_BLEND)
                        r_b[{er, ec}] <= sat32(rnd(r_acc + (r_rdv ? prod : 68'sd0), 15));
                    else
                        r_c[{er, ec}] <= sat32(r_acc + rnd(prod, FracBits));
                end else r_k <= r_k + 3'd1;
            end
            S_APPLY: begin
                if (r_k == 3'd0) r_acc <= 68'(r_c[{r_i[1:0], 2'd3}]) + rnd(prod, FracBits);
                else r_acc <= r_acc + rnd(prod, FracBits);
                if (r_k == 3'd2) begin
                    r_k <= 3'd3;
                end else if (r_k == 3'd3) begin
                    r_o[r_i[1:0]] <= sat32(r_acc);
                    r_acc <= '0;
                    r_k <= '0;
                    r_i <= r_i + 6'd1;
                end else r_k <= r_k + 3'd1;
            end
            default: ;
        endcase
    end

    // Bone valid tag and weight are registered alongside the read data
    always_ff @(posedge i_clk) begin
        r_rdv <= (bone < 11'(NumBones));
        r_wt  <= wt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == S_APPLY && n_st == S_OUT) r_ov <= 1'b1;
            else if (r_ov && !i_stall) r_ov <= 1'b0;
        end
    end

    assign o_valid = r_ov;
    assign o_x = r_o[0];
    assign o_y = r_o[1];
    assign o_z = r_o[2];
endmodule

// ----- tb/lbsv_checker.sv -----
// Checker for the vertex skinning block: watches both channels, keeps a shadow
// matrix table, predicts each skinned position and compares output beats.
// Depends on lbsv_pkg.
`timescale 1ns / 100ps

module lbsv_checker
    import lbsv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  t_item              i_item,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_out_x,
    input  logic signed [31:0] i_out_y,
    input  logic signed [31:0] i_out_z,
    output int                 o_errors,
    output int                 o_pending
);
    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pos;

    logic signed [31:0] shadow_tbl [TableWords];
    t_pos               expected_pos [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_shr(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint elem(input int slot, input int col, input int row);
        return longint'(shadow_tbl[slot * 16 + col * 4 + row]);
    endfunction

    function automatic t_pos skin_vertex(input t_item it);
        longint blend [4][4];
        longint comb [4][4];
        longint w [4];
        int     bn [4];
        longint acc;
        longint pv [3];
        longint res [3];
        t_pos   p;
        bn[0] = int'(it.bone_a);
        bn[1] = int'(it.bone_b);
        bn[2] = int'(it.bone_c);
        bn[3] = int'(it.bone_d);
        w[0] = longint'(it.weight_a);
        w[1] = longint'(it.weight_b);
        w[2] = longint'(it.weight_c);
        w[3] = longint'(it.weight_d);
        pv[0] = longint'(it.pos_x);
        pv[1] = longint'(it.pos_y);
        pv[2] = longint'(it.pos_z);
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                acc = 0;
                for (int k = 0; k < 4; k++) begin
                    if (bn[k] < NumBones) acc += w[k] * elem(bn[k], c, r);
                end
                blend[r][c] = clamp32(round_shr(acc, 15));
            end
        end
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                acc = 0;
                for (int j = 0; j < 4; j++) begin
                    acc += round_shr(elem(NumBones, j, r) * blend[j][c], FracBits);
                end
                comb[r][c] = clamp32(acc);
            end
        end
        for (int r = 0; r < 3; r++) begin
            acc = comb[r][3];
            for (int j = 0; j < 3; j++) begin
                acc += round_shr(comb[r][j] * pv[j], FracBits);
            end
            res[r] = clamp32(acc);
        end
        p.x = res[0][31:0];
        p.y = res[1][31:0];
        p.z = res[2][31:0];
        return p;
    endfunction

    initial begin
        o_errors = 0;
        foreach (shadow_tbl[i]) shadow_tbl[i] = '0;
    end

    assign o_pending = expected_pos.size();

    always @(posedge i_clk) begin
        t_pos want;
        if (i_rst_n && i_valid && !i_stall_in) begin
            if (i_item.action == 1'b0) begin
                if (i_item.bone_a < TableWords) shadow_tbl[i_item.bone_a] = i_item.pos_x;
            end else begin
                expected_pos.push_back(skin_vertex(i_item));
            end
        end
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_pos.size() == 0) begin
                $error("unexpected output beat x=%0d y=%0d z=%0d", i_out_x, i_out_y, i_out_z);
                o_errors++;
            end else begin
                want = expected_pos.pop_front();
                if (i_out_x !== want.x) begin
                    $error("out_x expected %0d got %0d", want.x, i_out_x);
                    o_errors++;
                end
                if (i_out_y !== want.y) begin
                    $error("out_y expected %0d got %0d", want.y, i_out_y);
                    o_errors++;
                end
                if (i_out_z !== want.z) begin
                    $error("out_z expected %0d got %0d", want.z, i_out_z);
                    o_errors++;
                end
            end
        end
    end
endmodule

// ----- tb/tb_linear_blend_skinning_vertex.sv -----
// Top of the vertex skinning testbench: clock, reset, write and skin beats,
// output stalls, and the verdict. Depends on lbsv_pkg, lbsv_checker and the block.
`timescale 1ns / 100ps

module tb_linear_blend_skinning_vertex;
    import lbsv_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    t_item              cur;
    int                 errors;
    int                 pending;
    int                 beats_sent;
    logic               calm;

    linear_blend_skinning_vertex dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_action   (cur.action),
        .i_bone_a   (cur.bone_a),
        .i_bone_b   (cur.bone_b),
        .i_bone_c   (cur.bone_c),
        .i_bone_d   (cur.bone_d),
        .i_weight_a (cur.weight_a),
        .i_weight_b (cur.weight_b),
        .i_weight_c (cur.weight_c),
        .i_weight_d (cur.weight_d),
        .i_pos_x    (cur.pos_x),
        .i_pos_y    (cur.pos_y),
        .i_pos_z    (cur.pos_z),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_x    (o_out_x),
        .o_out_y    (o_out_y),
        .o_out_z    (o_out_z)
    );

    lbsv_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_stall_in  (o_stall),
        .i_item      (cur),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out_x     (o_out_x),
        .i_out_y     (o_out_y),
        .i_out_z     (o_out_z),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("[linear_blend_skinning_vertex] ERROR");
        $finish;
    end

    function automatic t_item noise_item();
        t_item        it;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_item)-1:0];
        it.weight_a = 16'($urandom_range(32768));
        it.weight_b = 16'($urandom_range(32768));
        it.weight_c = 16'($urandom_range(32768));
        it.weight_d = 16'($urandom_range(32768));
        return it;
    endfunction

    function automatic t_item wr_item(input int addr, input logic signed [31:0] val);
        t_item it;
        it = noise_item();
        it.action = 1'b0;
        it.bone_a = 11'(addr);
        it.pos_x  = val;
        return it;
    endfunction

    function automatic t_item skin_item(input int ba, input int bb, input int bc,
                                        input int bd, input int wa, input int wb,
                                        input int wc, input int wd,
                                        input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z);
        t_item it;
        it = '{1'b1, 11'(ba), 6'(bb), 6'(bc), 6'(bd), 16'(wa), 16'(wb), 16'(wc),
               16'(wd), x, y, z};
        return it;
    endfunction

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(32'h80000)) - 32'sh40000;
        endcase
    endfunction

    task automatic send_beat(input t_item it);
        while (!calm && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        cur     <= it;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
    endtask

    initial begin
        i_stall = 1'b0;
        wait (beats_sent >= TableWords + 30);
        @(posedge i_clk);
        i_stall <= 1'b1;
        repeat (3000) @(posedge i_clk);
        forever begin
            i_stall <= !calm && ($urandom_range(99) < 21);
            @(posedge i_clk);
        end
    end

    initial begin
        t_item it;
        int    wl;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        cur        = '0;
        calm       = 1'b0;
        beats_sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // start every slot as identity
        for (int a = 0; a < TableWords; a++) begin
            send_beat(wr_item(a, ((a % 16) % 5 == 0) ? 32'sh10000 : 32'sh0));
        end

        send_beat(skin_item(0, 0, 0, 0, 32768, 0, 0, 0, 32'sh10000, -32'sh20000, 32'sh7));
        send_beat(skin_item(1, 2, 3, 63, 32768, 32768, 32768, 32768,
                            32'sh7fffffff, 32'sh80000000, 32'sh7fffffff));
        send_beat(skin_item(64, 5, 6, 7, 32768, 8192, 8192, 16384, 32'sh1, -32'sh1, 0));
        send_beat(skin_item(1039, 0, 0, 0, 0, 0, 0, 0, 32'sh12345, 32'sh54321, -32'sh9));
        send_beat(skin_item(63, 63, 63, 63, 65535 & 32768, 1, 0, 32767,
                            32'sh80000000, 0, 32'sh7fffffff));
        send_beat(wr_item(1040, 32'sh7fffffff));
        send_beat(wr_item(2047, 32'sh80000000));
        send_beat(wr_item(5 * 16 + 12, 32'sh7fffffff));
        send_beat(wr_item(5 * 16 + 0, 32'sh80000000));
        send_beat(skin_item(5, 5, 5, 5, 32768, 32768, 0, 0, 32'sh10000, 0, 0));
        send_beat(skin_item(5, 0, 0, 0, 32768, 0, 0, 0, 32'sh7fffffff, 0, 0));
        send_beat(wr_item(NumBones * 16 + 0, 32'sh7fffffff));
        send_beat(wr_item(NumBones * 16 + 13, 32'sh80000000));
        send_beat(skin_item(5, 1, 0, 0, 32768, 32768, 0, 0, 32'sh10000, -32'sh10000, 0));
        send_beat(skin_item(2, 0, 0, 0, 32768, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 0));

        for (int n = 0; n < 700; n++) begin
            calm = (n >= 300 && n < 420);
            if ($urandom_range(99) < 25) begin
                if ($urandom_range(9) == 0) begin
                    it = wr_item($urandom_range(2047, TableWords), $urandom);
                end else begin
                    it = wr_item($urandom_range(TableWords - 1), rand_val());
                end
            end else begin
                it = noise_item();
                it.action = 1'b1;
                it.bone_a = ($urandom_range(9) == 0) ? 11'($urandom_range(1039, NumBones))
                                                     : 11'($urandom_range(NumBones - 1));
                if ($urandom_range(2) != 0) begin
                    wl          = 32768;
                    it.weight_a = 16'($urandom_range(wl));
                    wl         -= int'(it.weight_a);
                    it.weight_b = 16'($urandom_range(wl));
                    wl         -= int'(it.weight_b);
                    it.weight_c = 16'($urandom_range(wl));
                    it.weight_d = 16'(wl - int'(it.weight_c));
                end
                if ($urandom_range(3) != 0) begin
                    it.pos_x = $signed($urandom_range(32'h2000000)) - 32'sh1000000;
                    it.pos_y = $signed($urandom_range(32'h2000000)) - 32'sh1000000;
                    it.pos_z = $signed($urandom_range(32'h2000000)) - 32'sh1000000;
                end
            end
            send_beat(it);
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[linear_blend_skinning_vertex] OK");
        end else begin
            $display("[linear_blend_skinning_vertex] ERROR");
        end
        $finish;
    end
endmodule
